>>> src/hscop_pkg.sv
`default_nettype none
package hscop_pkg;

  // Sequencer states; each oscillator runs FM..W3 once per tick
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FM,
    ST_XM,
    ST_SUM,
    ST_SQ,
    ST_RC,
    ST_SH,
    ST_SC,
    ST_ADV,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_FIN
  } hscop_state_t;

  // Register indexes
  localparam logic [2:0] REG_SLAVE_STEP  = 3'd0;
  localparam logic [2:0] REG_MASTER_STEP = 3'd1;
  localparam logic [2:0] REG_MAGNITUDES  = 3'd2;
  localparam logic [2:0] REG_FM_DEPTH    = 3'd3;
  localparam logic [2:0] REG_XMOD_SCALE  = 3'd4;
  localparam logic [2:0] REG_MODE        = 3'd5;
  localparam logic [2:0] REG_SLAVE_PW    = 3'd6;
  localparam logic [2:0] REG_MASTER_PW   = 3'd7;

  // Wave codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SAW    = 3'd1;
  localparam logic [2:0] WAVE_RSAW   = 3'd2;
  localparam logic [2:0] WAVE_SQUARE = 3'd3;
  localparam logic [2:0] WAVE_TRI    = 3'd4;
  localparam logic [2:0] WAVE_PULSE  = 3'd5;

  localparam int unsigned SINE_ENTRIES = 257;
  localparam logic [15:0] FM_DEPTH_RESET = 16'd40960;
  localparam logic [31:0] EXP_ONE       = 32'd134217728;
  localparam logic [31:0] EXP_RECIP     = 32'd715827883;
  localparam logic [31:0] EXP_OFFSET    = 32'd715827882;
  localparam logic [31:0] STEP_CLAMP    = 32'h7FFE0000;
  localparam logic [31:0] STEP_LIMIT_HI = 32'h00007FFE;
  localparam logic [16:0] MAG_FULL      = 17'd65536;

  typedef logic signed [15:0] quarter_arr_t [0:64];
  localparam quarter_arr_t QUARTER_SINE = '{
    16'sd0, 16'sd804, 16'sd1608, 16'sd2410, 16'sd3212, 16'sd4011, 16'sd4808,
    16'sd5602, 16'sd6393, 16'sd7179, 16'sd7962, 16'sd8739, 16'sd9512,
    16'sd10278, 16'sd11039, 16'sd11793, 16'sd12539, 16'sd13279, 16'sd14010,
    16'sd14732, 16'sd15446, 16'sd16151, 16'sd16846, 16'sd17530, 16'sd18204,
    16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403, 16'sd22005,
    16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811, 16'sd25329,
    16'sd25832, 16'sd26319, 16'sd26790, 16'sd27245, 16'sd27683, 16'sd28105,
    16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29956, 16'sd30273,
    16'sd30571, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785,
    16'sd31971, 16'sd32137, 16'sd32285, 16'sd32412, 16'sd32521, 16'sd32609,
    16'sd32678, 16'sd32728, 16'sd32757, 16'sd32767
  };

  // Full-cycle sine lookup, entry 256 equals entry 0
  function automatic logic signed [15:0] sine_lookup(input logic [8:0] idx);
    logic [6:0] k;
    logic signed [15:0] v;
    k = idx[6:0];
    if (k <= 7'd64) v = QUARTER_SINE[k];
    else v = QUARTER_SINE[7'd0 - k];
    return idx[7] ? -v : v;
  endfunction

endpackage
`default_nettype wire

>>> src/hard_sync_crossmod_oscillator_pair.sv
`default_nettype none
// Hard-sync master/slave oscillator pair with cross-modulation. Each accepted
// transaction is one sample tick; one transaction is worked at a time by a
// sequencer around a single shared 34x34 signed multiplier, with a master pass
// and then a slave pass through states FM to W3 before the finish state (idle
// goes straight to finish when both gains are zero). The sequencer holds in its
// finish state only while an untaken result still fills the output register.
// The next tick is taken once the sequencer is back in idle, even while the
// last result still waits in the output register.
// Registers sit at byte address 8*i on the 64-bit configuration port.
module hard_sync_crossmod_oscillator_pair
  import hscop_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_slave_fm_sample,
  input  wire logic               in_slave_fm_present,
  input  wire logic signed [15:0] in_master_fm_sample,
  input  wire logic               in_master_fm_present,
  input  wire logic signed [15:0] in_slave_shape_sample,
  input  wire logic               in_slave_shape_present,
  input  wire logic signed [15:0] in_master_shape_sample,
  input  wire logic               in_master_shape_present,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_slave_out,
  output logic signed [15:0]      out_master_out
);

  // configuration registers
  logic [30:0] slave_step_r, master_step_r;
  logic [33:0] magnitudes_r;
  logic [15:0] fm_depth_r, xmod_scale_r;
  logic [6:0]  mode_r;
  logic [31:0] slave_pw_r, master_pw_r;

  // sequencer and datapath
  hscop_state_t state_r, state_nxt;
  logic        sel_r;                 // 0 master pass, 1 slave pass
  logic [63:0] p_r;
  logic [31:0] n_r, sc_r;
  logic        mod_r, sync_r;
  logic [31:0] mphase_r, sphase_r;
  logic signed [15:0] msamp_r, ssamp_r;
  logic signed [15:0] t0_r;
  logic        out_valid_r;
  logic signed [15:0] out_slave_r, out_master_r;

  // latched input transaction
  logic signed [15:0] sfm_r, mfm_r;
  logic        sfm_pres_r, mfm_pres_r;
  logic [31:0] spw_r, mpw_r;

  logic cfg_wr, in_acc, mags_zero, xm_on, out_free;
  logic [2:0] cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[5:3];
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_slave_out  = out_slave_r;
  assign out_master_out = out_master_r;
  assign xm_on    = (xmod_scale_r != 16'd0);
  assign out_free = !out_valid_r || out_ready;

  // saturated gains
  logic [16:0] smag, mmag, cur_mag;
  assign smag = (magnitudes_r[16:0] > MAG_FULL) ? MAG_FULL : magnitudes_r[16:0];
  assign mmag = (magnitudes_r[33:17] > MAG_FULL) ? MAG_FULL : magnitudes_r[33:17];
  assign mags_zero = (smag == 17'd0) && (mmag == 17'd0);
  assign cur_mag = sel_r ? smag : mmag;

  // per-pass selections
  logic signed [15:0] cur_fm;
  logic        cur_fm_pres;
  logic [30:0] cur_base;
  logic [31:0] cur_phase, cur_pw;
  logic [2:0]  cur_wave;
  assign cur_fm      = sel_r ? sfm_r : mfm_r;
  assign cur_fm_pres = sel_r ? sfm_pres_r : mfm_pres_r;
  assign cur_base    = sel_r ? slave_step_r : master_step_r;
  assign cur_phase   = sel_r ? sphase_r : mphase_r;
  assign cur_pw      = sel_r ? spw_r : mpw_r;
  assign cur_wave    = sel_r ? mode_r[2:0] : mode_r[5:3];

  // register read
  always_comb begin
    prdata = 64'd0;
    case (cfg_idx)
      REG_SLAVE_STEP:  prdata = {33'd0, slave_step_r};
      REG_MASTER_STEP: prdata = {33'd0, master_step_r};
      REG_MAGNITUDES:  prdata = {30'd0, magnitudes_r};
      REG_FM_DEPTH:    prdata = {48'd0, fm_depth_r};
      REG_XMOD_SCALE:  prdata = {48'd0, xmod_scale_r};
      REG_MODE:        prdata = {57'd0, mode_r};
      REG_SLAVE_PW:    prdata = {32'd0, slave_pw_r};
      REG_MASTER_PW:   prdata = {32'd0, master_pw_r};
      default:         prdata = 64'd0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_step_r  <= '0;
      master_step_r <= '0;
      magnitudes_r  <= '0;
      fm_depth_r    <= FM_DEPTH_RESET;
      xmod_scale_r  <= '0;
      mode_r        <= '0;
      slave_pw_r    <= '0;
      master_pw_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SLAVE_STEP:  slave_step_r  <= pwdata[30:0];
        REG_MASTER_STEP: master_step_r <= pwdata[30:0];
        REG_MAGNITUDES:  magnitudes_r  <= pwdata[33:0];
        REG_FM_DEPTH:    fm_depth_r    <= pwdata[15:0];
        REG_XMOD_SCALE:  xmod_scale_r  <= pwdata[15:0];
        REG_MODE:        mode_r        <= pwdata[6:0];
        REG_SLAVE_PW:    slave_pw_r    <= pwdata[31:0];
        REG_MASTER_PW:   master_pw_r   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // exp2 and step helpers
  logic [30:0] sq_f, rc_f;
  logic [31:0] sh_f, sh_r32, adv_step;
  logic signed [6:0] sh_amt;
  logic [4:0]  sh_clamped;
  logic [32:0] adv_sum;
  assign sq_f = ({4'd0, n_r[26:0]} + EXP_ONE[30:0]) << 3;
  assign rc_f = 31'((p_r + 64'h80000000) >> 32);
  assign sh_f = 32'(((p_r + 64'h80000000) >> 32) << 3);
  assign sh_r32 = sh_f + EXP_OFFSET;
  assign sh_amt = 7'sd14 - {{2{n_r[31]}}, n_r[31:27]};
  assign sh_clamped = (sh_amt < 7'sd0) ? 5'd0 : sh_amt[4:0];
  assign adv_step = !mod_r ? {1'b0, cur_base}
                  : (p_r[63:32] < STEP_LIMIT_HI) ? p_r[47:16] : STEP_CLAMP;
  assign adv_sum = {1'b0, (sel_r && sync_r) ? 32'd0 : cur_phase} + {1'b0, adv_step};

  // wave helpers
  logic signed [15:0] tab0, tab1;
  logic [1:0]  top;
  logic signed [18:0] tri_v;
  logic signed [33:0] wave_opa;
  logic [15:0] lvl;
  logic        wave_hi;
  logic signed [15:0] wave_val;
  assign tab0 = sine_lookup({1'b0, cur_phase[31:24]});
  assign tab1 = sine_lookup({1'b0, cur_phase[31:24]} + 9'd1);
  assign top  = cur_phase[31:30];
  assign tri_v = (top == 2'd1 || top == 2'd2)
               ? (19'sh0FFFF - $signed({2'b0, cur_phase[31:15]}))
               : ($signed({2'b0, cur_phase[31:15]})
                  - ((top == 2'd3) ? 19'sh20000 : 19'sd0));

  always_comb begin
    case (cur_wave)
      WAVE_SINE: wave_opa = $signed({{18{t0_r[15]}}, t0_r}) <<< 16;
      WAVE_SAW:  wave_opa = 34'($signed(cur_phase[31:16]));
      WAVE_RSAW: wave_opa = 34'($signed(~cur_phase[31:16]));
      WAVE_TRI:  wave_opa = 34'(tri_v);
      default:   wave_opa = 34'sd0;
    endcase
    if (cur_wave == WAVE_SINE) wave_opa = wave_opa + $signed(p_r[33:0]);
  end

  assign lvl = (cur_mag[16:1] > 16'd32767) ? 16'd32767 : cur_mag[16:1];
  assign wave_hi = (cur_wave == WAVE_SQUARE) ? cur_phase[31] : (cur_phase < cur_pw);

  always_comb begin
    if (cur_mag == 17'd0) wave_val = 16'sd0;
    else begin
      case (cur_wave)
        WAVE_SINE:   wave_val = p_r[47:32];
        WAVE_SAW, WAVE_RSAW, WAVE_TRI: wave_val = p_r[31:16];
        WAVE_SQUARE, WAVE_PULSE: wave_val = wave_hi ? $signed(lvl) : -$signed(lvl);
        default:     wave_val = 16'sd0;
      endcase
    end
  end

  // shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    case (state_r)
      ST_FM: begin
        mul_a = 34'(cur_fm);
        mul_b = $signed({18'd0, fm_depth_r});
      end
      ST_XM: begin
        mul_a = 34'(msamp_r);
        mul_b = $signed({18'd0, xmod_scale_r});
      end
      ST_SQ: begin
        mul_a = $signed({3'd0, sq_f});
        mul_b = $signed({3'd0, sq_f});
      end
      ST_RC: begin
        mul_a = $signed({3'd0, rc_f});
        mul_b = $signed({2'd0, EXP_RECIP});
      end
      ST_SC: begin
        mul_a = $signed({3'd0, cur_base});
        mul_b = $signed({2'd0, sc_r});
      end
      ST_W1: begin
        mul_a = 34'(tab1) - 34'(tab0);
        mul_b = $signed({18'd0, cur_phase[23:8]});
      end
      ST_W2: begin
        mul_a = wave_opa;
        mul_b = $signed({17'd0, cur_mag});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = mags_zero ? ST_FIN : ST_FM;
      ST_FM:   state_nxt = ST_XM;
      ST_XM:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_RC;
      ST_RC:   state_nxt = ST_SH;
      ST_SH:   state_nxt = ST_SC;
      ST_SC:   state_nxt = ST_ADV;
      ST_ADV:  state_nxt = ST_W1;
      ST_W1:   state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_W3;
      ST_W3:   state_nxt = sel_r ? ST_FIN : ST_FM;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mphase_r    <= '0;
      sphase_r    <= '0;
      sync_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) sel_r <= 1'b0;
      else if (state_r == ST_W3) sel_r <= 1'b1;
      if (state_r == ST_ADV) begin
        if (sel_r) sphase_r <= adv_sum[31:0];
        else begin
          mphase_r <= adv_sum[31:0];
          sync_r   <= mode_r[6] && adv_sum[32];
        end
      end
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sfm_r      <= in_slave_fm_sample;
      sfm_pres_r <= in_slave_fm_present;
      mfm_r      <= in_master_fm_sample;
      mfm_pres_r <= in_master_fm_present;
      spw_r <= in_slave_shape_present
             ? {~in_slave_shape_sample[15], in_slave_shape_sample[14:0], 16'd0}
             : slave_pw_r;
      mpw_r <= in_master_shape_present
             ? {~in_master_shape_sample[15], in_master_shape_sample[14:0], 16'd0}
             : master_pw_r;
      if (mags_zero) begin
        msamp_r <= 16'sd0;
        ssamp_r <= 16'sd0;
      end
    end
    case (state_r)
      ST_FM, ST_XM, ST_SQ, ST_RC, ST_SC, ST_W1, ST_W2: p_r <= mul_p[63:0];
      default: ;
    endcase
    if (state_r == ST_XM) n_r <= cur_fm_pres ? p_r[31:0] : 32'd0;
    if (state_r == ST_SUM) begin
      n_r   <= n_r + ((sel_r && xm_on) ? p_r[31:0] : 32'd0);
      mod_r <= cur_fm_pres || (sel_r && xm_on);
    end
    if (state_r == ST_SH) sc_r <= sh_r32 >> sh_clamped;
    if (state_r == ST_W1) t0_r <= tab0;
    if (state_r == ST_W3) begin
      if (sel_r) ssamp_r <= wave_val;
      else msamp_r <= wave_val;
    end
    if (state_r == ST_FIN && out_free) begin
      out_slave_r  <= ssamp_r;
      out_master_r <= msamp_r;
    end
  end

  // checks
  a_zero_gain_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && mags_zero |=> state_r == ST_FIN)
    else $error("zero-gain tick did not skip to finish");

  a_slave_after_master: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FM && sel_r |-> $past(state_r) == ST_W3)
    else $error("slave pass started out of order");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished tick not delivered");

endmodule
`default_nettype wire

>>> bench/tb_hard_sync_crossmod_oscillator_pair.sv
`timescale 1ns / 1ps
module tb_hard_sync_crossmod_oscillator_pair;
  import hscop_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic signed [15:0] slave_fm;
    logic               slave_fm_on;
    logic signed [15:0] master_fm;
    logic               master_fm_on;
    logic signed [15:0] slave_shape;
    logic               slave_shape_on;
    logic signed [15:0] master_shape;
    logic               master_shape_on;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] slave_smp;
    logic signed [15:0] master_smp;
  } sample_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  tick_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_slave_out, out_master_out;

  tick_t        tick_q[$];
  sample_pair_t sample_q[$];
  int errors = 0;
  int cycles = 0;
  logic in_fire = 1'b0;
  int gap_left = 0, stall_left = 0;
  bit steady = 0;

  // Shadow configuration and oscillator state
  logic [30:0] sl_step, ms_step;
  logic [33:0] gains;
  logic [15:0] fm_depth, xmod;
  logic [6:0]  mode;
  logic [31:0] sl_pw, ms_pw;
  logic [31:0] sl_ph, ms_ph;
  int sine_tbl[0:256];

  hard_sync_crossmod_oscillator_pair uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_slave_fm_sample(cur.slave_fm), .in_slave_fm_present(cur.slave_fm_on),
    .in_master_fm_sample(cur.master_fm), .in_master_fm_present(cur.master_fm_on),
    .in_slave_shape_sample(cur.slave_shape),
    .in_slave_shape_present(cur.slave_shape_on),
    .in_master_shape_sample(cur.master_shape),
    .in_master_shape_present(cur.master_shape_on),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_slave_out(out_slave_out), .out_master_out(out_master_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // exp2 of a 5.27 fixed-point octave value, as a 16.16-ish multiplier
  function automatic logic [31:0] exp2_gain(input logic [31:0] n);
    int oct, sh;
    longint unsigned f;
    logic [31:0] r;
    oct = int'(n[31:27]);
    if (oct >= 16) oct -= 32;
    f = (longint'(n[26:0]) + 64'd134217728) << 3;
    f = (f * f + 64'h80000000) >> 32;
    f = ((f * 64'd715827883 + 64'h80000000) >> 32) << 3;
    r = f[31:0] + 32'd715827882;
    sh = 14 - oct;
    if (sh < 0) sh = 0;
    if (sh > 31) sh = 31;
    return r >> sh;
  endfunction

  function automatic logic [31:0] step_mul(input logic [31:0] base, input logic [31:0] sc);
    longint unsigned p;
    p = longint'(base) * longint'(sc);
    if (p[63:32] < 32'h7FFE) return p[47:16];
    return 32'h7FFE0000;
  endfunction

  function automatic logic signed [15:0] osc_sample(input logic [2:0] sel,
      input logic [31:0] ph, input int mag, input logic [31:0] pw);
    int lvl;
    longint acc, fr, v;
    lvl = mag >> 1;
    if (lvl > 32767) lvl = 32767;
    if (mag == 0) return '0;
    case (sel)
      WAVE_SINE: begin
        fr = longint'(ph[23:8]);
        acc = longint'(sine_tbl[ph[31:24]]) * (65536 - fr)
            + longint'(sine_tbl[int'(ph[31:24]) + 1]) * fr;
        acc = (acc * mag) >>> 32;
        return acc[15:0];
      end
      WAVE_SAW: begin
        acc = (longint'(mag) * longint'($signed(ph[31:16]))) >>> 16;
        return acc[15:0];
      end
      WAVE_RSAW: begin
        acc = (longint'(mag) * longint'($signed(~ph[31:16]))) >>> 16;
        return acc[15:0];
      end
      WAVE_SQUARE: return ph[31] ? 16'(lvl) : 16'(-lvl);
      WAVE_TRI: begin
        if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) v = 64'hFFFF - longint'(ph[31:15]);
        else v = longint'(ph[31:15]) - ((ph[31:30] == 2'd3) ? 64'h20000 : 64'd0);
        acc = (v * mag) >>> 16;
        return acc[15:0];
      end
      WAVE_PULSE: return (ph < pw) ? 16'(lvl) : 16'(-lvl);
      default: return '0;
    endcase
  endfunction

  // One tick of the oscillator pair; advances the shadow phases unless both gains are zero
  function automatic sample_pair_t tick_pair(input tick_t t);
    sample_pair_t r;
    int smag, mmag;
    logic [31:0] minc, sinc, prior, mpw, spw, tot;
    logic sync_hit;
    smag = (gains[16:0] > 17'd65536) ? 65536 : int'(gains[16:0]);
    mmag = (gains[33:17] > 17'd65536) ? 65536 : int'(gains[33:17]);
    if (smag == 0 && mmag == 0) return '0;
    minc = {1'b0, ms_step};
    sinc = {1'b0, sl_step};
    if (t.master_fm_on)
      minc = step_mul(minc, exp2_gain(32'(int'(t.master_fm) * int'(fm_depth))));
    prior = ms_ph;
    ms_ph = ms_ph + minc;
    sync_hit = mode[6] && (ms_ph < prior);
    mpw = t.master_shape_on ? {t.master_shape ^ 16'h8000, 16'h0} : ms_pw;
    r.master_smp = osc_sample(mode[5:3], ms_ph, mmag, mpw);
    if (t.slave_fm_on || xmod != 0) begin
      tot = '0;
      if (t.slave_fm_on) tot = 32'(int'(t.slave_fm) * int'(fm_depth));
      if (xmod != 0) tot = tot + 32'(int'(r.master_smp) * int'(xmod));
      sinc = step_mul(sinc, exp2_gain(tot));
    end
    if (sync_hit) sl_ph = '0;
    sl_ph = sl_ph + sinc;
    spw = t.slave_shape_on ? {t.slave_shape ^ 16'h8000, 16'h0} : sl_pw;
    r.slave_smp = osc_sample(mode[2:0], sl_ph, smag, spw);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  function automatic int draw_gap();
    if (steady) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tick_t draw_tick();
    tick_t t;
    t.slave_fm = draw_sample();
    t.master_fm = draw_sample();
    t.slave_shape = draw_sample();
    t.master_shape = draw_sample();
    t.slave_fm_on = $urandom_range(0, 1);
    t.master_fm_on = $urandom_range(0, 1);
    t.slave_shape_on = $urandom_range(0, 1);
    t.master_shape_on = $urandom_range(0, 1);
    return t;
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SLAVE_STEP:  sl_step = val[30:0];
      REG_MASTER_STEP: ms_step = val[30:0];
      REG_MAGNITUDES:  gains = val[33:0];
      REG_FM_DEPTH:    fm_depth = val[15:0];
      REG_XMOD_SCALE:  xmod = val[15:0];
      REG_MODE:        mode = val[6:0];
      REG_SLAVE_PW:    sl_pw = val[31:0];
      default:         ms_pw = val[31:0];
    endcase
  endtask

  task automatic write_all(input logic [63:0] v[8]);
    for (int i = 0; i < 8; i++) reg_write(3'(i), v[i]);
  endtask

  function automatic logic [63:0] pick(input logic [63:0] lo, input logic [63:0] hi,
      input logic [63:0] rnd);
    case ($urandom_range(0, 4))
      0: return lo;
      1: return hi;
      default: return rnd;
    endcase
  endfunction

  // Wait until nothing is pending or in flight, checked again after settling
  task automatic drain();
    do begin
      wait (tick_q.size() == 0 && sample_q.size() == 0 && !in_valid);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (tick_q.size() != 0 || sample_q.size() != 0 || in_valid);
  endtask

  // Input acceptance: predict and queue the expected samples
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (in_valid && in_ready) sample_q.push_back(tick_pair(cur));
  end

  // Input driver
  always @(negedge clk) begin
    if (!(in_valid && !in_fire)) begin
      if (gap_left > 0 || !rst_n || tick_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        cur <= tick_q.pop_front();
        in_valid <= 1'b1;
        gap_left = draw_gap();
      end
    end
  end

  // Output ready with random stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = draw_gap();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_slave_out, 0);
      end else begin
        sample_pair_t e;
        e = sample_q.pop_front();
        if (out_slave_out !== e.slave_smp)
          report_mismatch("slave_out", out_slave_out, e.slave_smp);
        if (out_master_out !== e.master_smp)
          report_mismatch("master_out", out_master_out, e.master_smp);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_hard_sync_crossmod_oscillator_pair failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] regs[8];
    for (int i = 0; i <= 256; i++) begin
      int k, v;
      k = i & 127;
      v = (k <= 64) ? QUARTER_SINE[k] : QUARTER_SINE[128 - k];
      sine_tbl[i] = (i == 256) ? 0 : ((i & 128) ? -v : v);
    end
    sl_step = '0; ms_step = '0; gains = '0; fm_depth = 16'd40960; xmod = '0;
    mode = '0; sl_pw = '0; ms_pw = '0; sl_ph = '0; ms_ph = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: both gains zero, phases hold
    for (int i = 0; i < 3; i++) tick_q.push_back(draw_tick());
    drain();

    // Directed: each wave code on both oscillators, sync on, full gains
    regs = '{64'h0100_0000, 64'h0345_6789, 64'h3_FFFF_FFFF, 64'd409, 64'd0,
             64'd0, 64'h8000_0000, 64'h4000_0000};
    write_all(regs);
    for (int w = 0; w < 8; w++) begin
      reg_write(REG_MODE, {57'd0, 1'b1, 3'(7 - w), 3'(w)});
      for (int i = 0; i < 3; i++) begin
        tick_t t;
        t = draw_tick();
        if (i == 0) t = '{16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 16'sh8000, 1'b1,
                          16'sh7FFF, 1'b1};
        tick_q.push_back(t);
      end
      drain();
    end
    // One gain zero, steps at extremes, cross-mod full
    regs = '{64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h2_0000_0000, 64'd49152, 64'hFFFF,
             64'h40, 64'hFFFF_FFFF, 64'h0};
    write_all(regs);
    for (int i = 0; i < 3; i++) tick_q.push_back(draw_tick());
    drain();

    // Random phases
    for (int ph = 0; ph < 12; ph++) begin
      steady = (ph % 4 == 3);
      regs[0] = pick(0, 64'h7FFF_FFFF, (ph < 8) ? $urandom_range(0, 32'h0400_0000)
                                                 : {$urandom, $urandom});
      regs[1] = pick(0, 64'h7FFF_FFFF, (ph < 8) ? $urandom_range(0, 32'h0800_0000)
                                                 : {$urandom, $urandom});
      regs[2] = pick(0, 64'h3_FFFF_FFFF, {$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) regs[2] = {$urandom_range(0, 65536), 17'd0}
                                                | $urandom_range(0, 65536);
      regs[3] = pick(64'd409, 64'd49152, $urandom_range(0, 65535));
      regs[4] = pick(0, 64'hFFFF, $urandom_range(0, 65535));
      regs[5] = $urandom_range(0, 127);
      regs[6] = pick(0, 64'hFFFF_FFFF, $urandom);
      regs[7] = pick(0, 64'hFFFF_FFFF, $urandom);
      write_all(regs);
      for (int i = 0; i < 40; i++) tick_q.push_back(draw_tick());
      drain();
    end

    if (errors == 0 && sample_q.size() == 0) begin
      $display("tb_hard_sync_crossmod_oscillator_pair passed");
    end else begin
      $display("tb_hard_sync_crossmod_oscillator_pair failed");
    end
    $finish;
  end

endmodule
